[rtl/dmt_pkg.sv]
package dmt_pkg;

    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;
    localparam int RIDX_W = 6;
    localparam int DCNT_W = 7;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
        logic              cls;
        logic [RIDX_W-1:0] ridx;
    } cmd_t;

    typedef struct packed {
        logic              matched_existing;
        logic              added_new;
        logic              was_dropped;
        logic              entry_valid;
        logic [RIDX_W-1:0] entry_index;
        logic [ADDR_W-1:0] entry_address;
        logic              entry_class;
        logic [CNT_W-1:0]  entry_hits;
        logic [DCNT_W-1:0] distinct_count;
        logic [CNT_W-1:0]  total_misses;
        logic [CNT_W-1:0]  dropped_misses;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

[rtl/dmt_if.sv]
interface dmt_item_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [dmt_pkg::ADDR_W-1:0] target_address;
    logic                       miss_class;
    logic [dmt_pkg::RIDX_W-1:0] read_index;

    modport source (output valid, kind, target_address, miss_class, read_index, input ready);
    modport sink (input valid, kind, target_address, miss_class, read_index, output ready);
endinterface

interface dmt_result_if;
    logic                       valid;
    logic                       ready;
    logic                       matched_existing;
    logic                       added_new;
    logic                       was_dropped;
    logic                       entry_valid;
    logic [dmt_pkg::RIDX_W-1:0] entry_index;
    logic [dmt_pkg::ADDR_W-1:0] entry_address;
    logic                       entry_class;
    logic [dmt_pkg::CNT_W-1:0]  entry_hits;
    logic [dmt_pkg::DCNT_W-1:0] distinct_count;
    logic [dmt_pkg::CNT_W-1:0]  total_misses;
    logic [dmt_pkg::CNT_W-1:0]  dropped_misses;

    modport source (output valid, matched_existing, added_new, was_dropped, entry_valid,
                    entry_index, entry_address, entry_class, entry_hits, distinct_count,
                    total_misses, dropped_misses, input ready);
    modport sink (input valid, matched_existing, added_new, was_dropped, entry_valid,
                  entry_index, entry_address, entry_class, entry_hits, distinct_count,
                  total_misses, dropped_misses, output ready);
endinterface

[rtl/dmt_front.sv]
module dmt_front (
    input  logic           clk,
    input  logic           rst_n,
    dmt_item_if.sink       item,
    output logic           cmd_valid,
    output dmt_pkg::cmd_t  cmd,
    input  logic           cmd_pop
);

    dmt_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          push;
    dmt_pkg::cmd_t new_cmd;

    assign item.ready = (count_reg != 2'd2);
    assign push       = item.valid && item.ready;
    assign cmd_valid  = (count_reg != 2'd0);
    assign cmd        = q_reg[rd_ptr_reg];

    always_comb
    begin
        new_cmd.op      = item.kind ? dmt_pkg::OP_READ : dmt_pkg::OP_RECORD;
        new_cmd.address = item.target_address;
        new_cmd.cls     = item.miss_class;
        new_cmd.ridx    = item.read_index;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

[rtl/dmt_back.sv]
module dmt_back #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  dmt_pkg::cmd_t  cmd,
    output logic           cmd_pop,
    dmt_result_if.source   result
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > dmt_pkg::DCNT_W) ? CW : dmt_pkg::DCNT_W;
    localparam int KW = dmt_pkg::ADDR_W + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [IW-1:0]              idx_reg, idx_next;
    logic [dmt_pkg::ADDR_W-1:0] key_addr_reg, key_addr_next;
    logic                       key_cls_reg, key_cls_next;
    logic [CW-1:0]              filled_reg, filled_next;
    logic [dmt_pkg::CNT_W-1:0]  total_reg, total_next;
    logic [dmt_pkg::CNT_W-1:0]  dropped_reg, dropped_next;
    logic                       out_valid_reg;
    dmt_pkg::result_t           out_reg;

    logic [KW-1:0]              key_mem [TABLE_DEPTH];
    logic [dmt_pkg::CNT_W-1:0]  hit_mem [TABLE_DEPTH];
    logic [KW-1:0]              rd_key;
    logic [dmt_pkg::CNT_W-1:0]  rd_hits;
    logic                       rd_en;
    logic [IW-1:0]              rd_addr;
    logic                       key_wr_en;
    logic                       hit_wr_en;
    logic [IW-1:0]              wr_addr;
    logic [KW-1:0]              key_wr_data;
    logic [dmt_pkg::CNT_W-1:0]  hit_wr_data;

    logic                       out_free;
    logic                       load_out;
    logic                       do_append;
    logic                       do_match;
    logic                       do_drop;
    logic                       key_match;
    dmt_pkg::result_t           res;
    logic [XW-1:0]              ridx_x;
    logic [XW-1:0]              filled_x;
    logic [XW-1:0]              filled_next_x;
    logic [XW-1:0]              idx_x;
    logic [dmt_pkg::CNT_W-1:0]  new_hits;

    assign out_free  = !out_valid_reg || result.ready;
    assign ridx_x    = XW'(cmd.ridx);
    assign filled_x  = XW'(filled_reg);
    assign idx_x     = XW'(idx_reg);
    assign key_match = (rd_key == {key_addr_reg, key_cls_reg});
    assign new_hits  = dmt_pkg::sat_inc(rd_hits);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        key_addr_next = key_addr_reg;
        key_cls_next  = key_cls_reg;
        filled_next   = filled_reg;
        total_next    = total_reg;
        dropped_next  = dropped_reg;
        cmd_pop       = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = idx_reg;
        key_wr_en     = 1'b0;
        hit_wr_en     = 1'b0;
        wr_addr       = IW'(filled_reg);
        key_wr_data   = {key_addr_reg, key_cls_reg};
        hit_wr_data   = new_hits;
        load_out      = 1'b0;
        do_append     = 1'b0;
        do_match      = 1'b0;
        do_drop       = 1'b0;
        res           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop       = 1'b1;
                    key_addr_next = cmd.address;
                    key_cls_next  = cmd.cls;
                    if (cmd.op == dmt_pkg::OP_READ)
                    begin
                        if (ridx_x < filled_x)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = IW'(cmd.ridx);
                            idx_next   = IW'(cmd.ridx);
                            state_next = S_READ;
                        end
                        else
                        begin
                            load_out        = 1'b1;
                            res.entry_index = cmd.ridx;
                        end
                    end
                    else
                    begin
                        total_next = dmt_pkg::sat_inc(total_reg);
                        if (filled_reg == '0)
                        begin
                            do_append   = 1'b1;
                            key_wr_data = {cmd.address, cmd.cls};
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            state_next = S_SEARCH;
                        end
                    end
                end
            end
            S_SEARCH:
            begin
                if (key_match)
                begin
                    do_match   = 1'b1;
                    state_next = S_IDLE;
                end
                else if ((CW'(idx_reg) + CW'(1)) < filled_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (filled_reg == DEPTH_C)
                begin
                    do_drop    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    do_append  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                load_out          = 1'b1;
                res.entry_valid   = 1'b1;
                res.entry_index   = idx_x[dmt_pkg::RIDX_W-1:0];
                res.entry_address = rd_key[KW-1:1];
                res.entry_class   = rd_key[0];
                res.entry_hits    = rd_hits;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_append)
        begin
            key_wr_en         = 1'b1;
            hit_wr_en         = 1'b1;
            wr_addr           = IW'(filled_reg);
            hit_wr_data       = dmt_pkg::CNT_W'(1);
            filled_next       = filled_reg + 1'b1;
            load_out          = 1'b1;
            res.added_new     = 1'b1;
            res.entry_valid   = 1'b1;
            res.entry_index   = filled_x[dmt_pkg::RIDX_W-1:0];
            res.entry_address = key_wr_data[KW-1:1];
            res.entry_class   = key_wr_data[0];
            res.entry_hits    = dmt_pkg::CNT_W'(1);
        end

        if (do_match)
        begin
            hit_wr_en            = 1'b1;
            wr_addr              = idx_reg;
            hit_wr_data          = new_hits;
            load_out             = 1'b1;
            res.matched_existing = 1'b1;
            res.entry_valid      = 1'b1;
            res.entry_index      = idx_x[dmt_pkg::RIDX_W-1:0];
            res.entry_address    = key_addr_reg;
            res.entry_class      = key_cls_reg;
            res.entry_hits       = new_hits;
        end

        if (do_drop)
        begin
            dropped_next    = dmt_pkg::sat_inc(dropped_reg);
            load_out        = 1'b1;
            res.was_dropped = 1'b1;
        end

        filled_next_x      = XW'(filled_next);
        res.distinct_count = filled_next_x[dmt_pkg::DCNT_W-1:0];
        res.total_misses   = total_next;
        res.dropped_misses = dropped_next;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key  <= key_mem[rd_addr];
            rd_hits <= hit_mem[rd_addr];
        end
        if (key_wr_en)
        begin
            key_mem[wr_addr] <= key_wr_data;
        end
        if (hit_wr_en)
        begin
            hit_mem[wr_addr] <= hit_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            filled_reg    <= '0;
            total_reg     <= '0;
            dropped_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            filled_reg  <= filled_next;
            total_reg   <= total_next;
            dropped_reg <= dropped_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_addr_reg <= key_addr_next;
        key_cls_reg  <= key_cls_next;
        if (load_out)
        begin
            out_reg <= res;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.matched_existing = out_reg.matched_existing;
    assign result.added_new        = out_reg.added_new;
    assign result.was_dropped      = out_reg.was_dropped;
    assign result.entry_valid      = out_reg.entry_valid;
    assign result.entry_index      = out_reg.entry_index;
    assign result.entry_address    = out_reg.entry_address;
    assign result.entry_class      = out_reg.entry_class;
    assign result.entry_hits       = out_reg.entry_hits;
    assign result.distinct_count   = out_reg.distinct_count;
    assign result.total_misses     = out_reg.total_misses;
    assign result.dropped_misses   = out_reg.dropped_misses;

endmodule

[rtl/distinct_miss_tally_table_top.sv]
// Distinct miss tally table.
// item channel (sink): one transaction per miss record (kind 0) or table read (kind 1).
// result channel (source): exactly one transaction per item, in item order.
// A two-entry queue behind the item port lets the sender run ahead of the
// search engine; the engine owns a single-port key/hit memory of TABLE_DEPTH
// entries and steps through it one entry per cycle.
// A read of a filled entry goes from acceptance through the memory read and
// the read state to the result register; a read beyond the filled entries
// and a record on an empty table are answered straight from idle; any other
// record walks the filled entries in turn until a match or the end of the
// fill. Items are handled one at a time, so with a ready receiver the engine
// takes the next transaction in the cycle after a result is loaded.
// Reset empties the table and clears the running and dropped totals at once;
// the memory itself is not cleared, only entries below the fill count are read.
// When the receiver stalls, the result holds in the output register, the
// engine takes no further transaction, and the queue fills and then lowers
// item ready.
module distinct_miss_tally_table_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    dmt_item_if.sink      item,
    dmt_result_if.source  result
);

    logic          cmd_valid;
    logic          cmd_pop;
    dmt_pkg::cmd_t cmd;

    dmt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    dmt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .result    (result)
    );

endmodule

[rtl/dmt_checker.sv]
module dmt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic                       matched_existing,
    input logic                       added_new,
    input logic                       was_dropped,
    input logic                       entry_valid,
    input logic [dmt_pkg::CNT_W-1:0]  entry_hits,
    input logic [dmt_pkg::CNT_W-1:0]  total_misses,
    input logic [dmt_pkg::CNT_W-1:0]  dropped_misses
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(entry_hits) && $stable(total_misses))
        else $error("stalled result changed");

    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $countones({matched_existing, added_new, was_dropped}) <= 1)
        else $error("more than one record outcome");

    a_record_entry: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (matched_existing || added_new) |->
            entry_valid && entry_hits != '0 && total_misses != '0)
        else $error("stored record without valid entry or counts");

    a_new_entry_hits: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && added_new |-> entry_hits == dmt_pkg::CNT_W'(1))
        else $error("new entry hit count not one");

    a_drop_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && was_dropped |-> !entry_valid && dropped_misses != '0)
        else $error("dropped record not counted");

endmodule

bind distinct_miss_tally_table_top dmt_checker u_dmt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .matched_existing (result.matched_existing),
    .added_new        (result.added_new),
    .was_dropped      (result.was_dropped),
    .entry_valid      (result.entry_valid),
    .entry_hits       (result.entry_hits),
    .total_misses     (result.total_misses),
    .dropped_misses   (result.dropped_misses)
);
